// ===== sv/trie_shortest_unique_prefix_top_assert.svh =====
// assertion macros shared by the trie prefix block
// no dependencies; included by the modules that carry assertions
`ifndef TRIE_SHORTEST_UNIQUE_PREFIX_TOP_ASSERT_SVH
`define TRIE_SHORTEST_UNIQUE_PREFIX_TOP_ASSERT_SVH

// condition holds at every edge outside reset
`define TSUP_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) \
    else $error(msg);

// same-cycle implication outside reset
`define TSUP_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/tsup_pkg.sv =====
// package for the trie shortest-unique-prefix block: constants, codes, types
// no dependencies; used by tsup_link_mem and the top level
package tsup_pkg;

  // default sizes
  localparam int DEF_POOL_NODES = 4096;
  localparam int DEF_ALPHABET   = 26;
  localparam int DEF_MAX_WORD   = 64;

  // fixed field widths
  localparam int OPCODE_W = 1;
  localparam int LETTER_W = 5;
  localparam int STATUS_W = 2;
  localparam int PLEN_W   = 7;

  // pass counts saturate
  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // word opcodes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_POOL_FULL = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // link memory access controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } lmem_ctl_t;

endpackage

// ===== sv/trie_shortest_unique_prefix_top.sv =====
// top level of the trie shortest-unique-prefix block: word walk control,
// pass count memory and result register; depends on tsup_pkg, tsup_link_mem
//
// channel | direction | handshake        | payload
// in      | input     | in_valid/stall   | in_opcode, in_letter, in_last_of_word
// out     | output    | out_valid/stall  | out_status, out_prefix_length
//
// each letter goes through link read at accept, count read, then update
// the walk is bound by the link memory read followed by the count memory read
// after reset all POOL_NODES*ALPHABET links of the link memory are swept clear,
// with in_stall high
// a result waits in the output register; a last letter holds in the update
// stage only while that register is full and stalled
`include "trie_shortest_unique_prefix_top_assert.svh"

module trie_shortest_unique_prefix_top #(
  parameter int POOL_NODES = tsup_pkg::DEF_POOL_NODES,
  parameter int ALPHABET   = tsup_pkg::DEF_ALPHABET,
  parameter int MAX_WORD   = tsup_pkg::DEF_MAX_WORD
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tsup_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [tsup_pkg::LETTER_W-1:0] in_letter,
  input  logic                          in_last_of_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tsup_pkg::STATUS_W-1:0] out_status,
  output logic [tsup_pkg::PLEN_W-1:0]   out_prefix_length
);
  import tsup_pkg::*;

  localparam int NODE_W  = $clog2(POOL_NODES);
  localparam int FREE_W  = NODE_W + 1;
  localparam int LINK_W  = NODE_W + 1;
  localparam int SYM_W   = $clog2(ALPHABET);
  localparam int LIDX_W  = $clog2(POOL_NODES * ALPHABET);
  localparam int DEPTH_W = $clog2(MAX_WORD + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CNT  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic                in_word_r, in_word_nxt;
  logic                query_r, query_nxt;
  logic                stopped_r, stopped_nxt;
  logic                found_r, found_nxt;
  logic [NODE_W-1:0]   cursor_r, cursor_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [DEPTH_W-1:0]  best_r, best_nxt;
  logic                walk_r, walk_nxt;
  logic                last_r, last_nxt;
  logic [LIDX_W-1:0]   idx_r, idx_nxt;
  logic [FREE_W-1:0]   next_free_r, next_free_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [PLEN_W-1:0]   out_plen_r, out_plen_nxt;

  logic                in_accept;
  logic                upd_go;
  logic                word_start;
  logic [SYM_W-1:0]    sym;
  logic [NODE_W-1:0]   cursor_eff;
  logic [DEPTH_W-1:0]  depth_eff;
  logic [LIDX_W-1:0]   rd_idx;

  lmem_ctl_t           lmem_ctl;
  logic [LINK_W-1:0]   link_q;
  logic [LINK_W-1:0]   link_wr_data;
  logic                lmem_busy;

  logic [COUNT_W-1:0]  cnt_mem [POOL_NODES];
  logic [COUNT_W-1:0]  cnt_q_r;
  logic                cnt_we;
  logic [NODE_W-1:0]   cnt_wa;
  logic [COUNT_W-1:0]  cnt_wd;

  logic                have;
  logic                have_nx;
  logic [NODE_W-1:0]   child;
  logic [NODE_W-1:0]   child_nx;
  logic                pool_ok;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE) || lmem_busy;
  assign upd_go    = (state_r == S_UPD) && (!last_r || !out_valid_r || !out_stall);

  // letter decode and link address of the current node
  always_comb begin
    word_start = !in_word_r;
    sym        = (32'(in_letter) >= ALPHABET) ? SYM_W'(ALPHABET - 1) : SYM_W'(in_letter);
    cursor_eff = word_start ? '0 : cursor_r;
    depth_eff  = word_start ? '0 : depth_r;
    rd_idx     = LIDX_W'(cursor_eff) * LIDX_W'(ALPHABET) + LIDX_W'(sym);
  end

  // link read at accept, allocation write at update
  assign lmem_ctl.rd_en = in_accept;
  assign lmem_ctl.wr_en = upd_go && walk_r && !query_r && !have && pool_ok;
  assign link_wr_data   = {1'b1, child_nx};

  tsup_link_mem #(
    .POOL_NODES(POOL_NODES),
    .ALPHABET  (ALPHABET)
  ) u_link_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lmem_ctl),
    .rd_idx (rd_idx),
    .wr_idx (idx_r),
    .wr_data(link_wr_data),
    .rd_data(link_q),
    .busy   (lmem_busy)
  );

  // pass count memory, read in the count stage, written at update
  always_ff @(posedge clk) begin
    if (state_r == S_CNT) begin
      cnt_q_r <= cnt_mem[child];
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
  end

  // walk step: count update, allocation, query check, result
  always_comb begin
    have          = link_q[NODE_W];
    child         = link_q[NODE_W-1:0];
    pool_ok       = next_free_r < FREE_W'(POOL_NODES);
    have_nx       = have;
    child_nx      = child;
    cnt_we        = 1'b0;
    cnt_wa        = child;
    cnt_wd        = cnt_q_r;
    next_free_nxt = next_free_r;
    state_nxt     = state_r;
    in_word_nxt   = in_word_r;
    query_nxt     = query_r;
    stopped_nxt   = stopped_r;
    found_nxt     = found_r;
    cursor_nxt    = cursor_r;
    depth_nxt     = depth_r;
    best_nxt      = best_r;
    walk_nxt      = walk_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_plen_nxt  = out_plen_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          in_word_nxt = 1'b1;
          query_nxt   = word_start ? (in_opcode == OP_QUERY) : query_r;
          stopped_nxt = word_start ? 1'b0 : stopped_r;
          found_nxt   = word_start ? 1'b0 : found_r;
          best_nxt    = word_start ? '0 : best_r;
          cursor_nxt  = cursor_eff;
          depth_nxt   = depth_eff;
          walk_nxt    = !stopped_nxt && (depth_eff < DEPTH_W'(MAX_WORD));
          last_nxt    = in_last_of_word;
          idx_nxt     = rd_idx;
          state_nxt   = S_CNT;
        end
      end
      S_CNT: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_go) begin
          if (walk_r) begin
            if (!query_r) begin
              if (have) begin
                cnt_we = 1'b1;
                cnt_wd = (cnt_q_r < COUNT_MAX) ? cnt_q_r + COUNT_W'(1) : cnt_q_r;
              end else if (pool_ok) begin
                child_nx      = next_free_r[NODE_W-1:0];
                cnt_we        = 1'b1;
                cnt_wa        = child_nx;
                cnt_wd        = COUNT_W'(1);
                next_free_nxt = next_free_r + FREE_W'(1);
                have_nx       = 1'b1;
              end
            end else if (have && !found_r && (cnt_q_r == COUNT_W'(1))) begin
              best_nxt  = depth_r + DEPTH_W'(1);
              found_nxt = 1'b1;
            end
            if (have_nx) begin
              cursor_nxt = child_nx;
              depth_nxt  = depth_r + DEPTH_W'(1);
            end else begin
              stopped_nxt = 1'b1;
            end
          end
          // word result at its last letter
          if (last_r) begin
            in_word_nxt   = 1'b0;
            out_valid_nxt = 1'b1;
            if (!query_r) begin
              out_status_nxt = stopped_nxt ? ST_POOL_FULL : ST_OK;
              out_plen_nxt   = '0;
            end else if (stopped_nxt) begin
              out_status_nxt = ST_NOT_FOUND;
              out_plen_nxt   = '0;
            end else begin
              out_status_nxt = ST_OK;
              out_plen_nxt   = PLEN_W'(found_nxt ? best_nxt : depth_nxt);
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_word_r   <= 1'b0;
      query_r     <= 1'b0;
      stopped_r   <= 1'b0;
      found_r     <= 1'b0;
      cursor_r    <= '0;
      depth_r     <= '0;
      best_r      <= '0;
      walk_r      <= 1'b0;
      last_r      <= 1'b0;
      next_free_r <= FREE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_word_r   <= in_word_nxt;
      query_r     <= query_nxt;
      stopped_r   <= stopped_nxt;
      found_r     <= found_nxt;
      cursor_r    <= cursor_nxt;
      depth_r     <= depth_nxt;
      best_r      <= best_nxt;
      walk_r      <= walk_nxt;
      last_r      <= last_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_plen_r   <= out_plen_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_prefix_length = out_plen_r;

  `TSUP_ASSERT_ALWAYS(a_pool_bound, clk, rst_n, next_free_r <= FREE_W'(POOL_NODES), "node pool pointer past end")
  `TSUP_ASSERT_ALWAYS(a_depth_bound, clk, rst_n, depth_r <= DEPTH_W'(MAX_WORD), "word depth past limit")
  `TSUP_ASSERT_IMPL(a_result_source, clk, rst_n, $rose(out_valid_r), $past(state_r == S_UPD && last_r), "result without last letter update")
  `TSUP_ASSERT_IMPL(a_query_no_alloc, clk, rst_n, query_r && upd_go, !lmem_ctl.wr_en && !cnt_we, "query walk wrote the trie")

endmodule

// ===== sv/tsup_link_mem.sv =====
// child link memory of the trie, one link per node and letter, with reset sweep
// depends on tsup_pkg and trie_shortest_unique_prefix_top_assert.svh
`include "trie_shortest_unique_prefix_top_assert.svh"

module tsup_link_mem #(
  parameter int POOL_NODES = tsup_pkg::DEF_POOL_NODES,
  parameter int ALPHABET   = tsup_pkg::DEF_ALPHABET
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  tsup_pkg::lmem_ctl_t                      ctl,
  input  logic [$clog2(POOL_NODES*ALPHABET)-1:0]   rd_idx,
  input  logic [$clog2(POOL_NODES*ALPHABET)-1:0]   wr_idx,
  input  logic [$clog2(POOL_NODES):0]              wr_data,
  output logic [$clog2(POOL_NODES):0]              rd_data,
  output logic                                     busy
);
  import tsup_pkg::*;

  localparam int LINK_DEPTH = POOL_NODES * ALPHABET;
  localparam int LIDX_W     = $clog2(LINK_DEPTH);
  localparam int LINK_W     = $clog2(POOL_NODES) + 1;
  localparam logic [LIDX_W-1:0] CLR_LAST = LIDX_W'(LINK_DEPTH - 1);

  logic [LINK_W-1:0] mem [LINK_DEPTH];
  logic [LINK_W-1:0] rd_data_r;
  logic              clr_r;
  logic              clr_nxt;
  logic [LIDX_W-1:0] clr_idx_r;
  logic [LIDX_W-1:0] clr_idx_nxt;

  // clearing sweep, one link per cycle after reset
  always_comb begin
    clr_nxt     = clr_r;
    clr_idx_nxt = clr_idx_r;
    if (clr_r) begin
      clr_idx_nxt = clr_idx_r + LIDX_W'(1);
      if (clr_idx_r == CLR_LAST) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // single write port shared by the sweep and link allocation
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_idx_r] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_r;

  `TSUP_ASSERT_IMPL(a_no_rd_in_sweep, clk, rst_n, clr_r, !ctl.rd_en, "link read during clear sweep")
  `TSUP_ASSERT_IMPL(a_no_wr_in_sweep, clk, rst_n, clr_r, !ctl.wr_en, "link write during clear sweep")
  `TSUP_ASSERT_IMPL(a_sweep_complete, clk, rst_n, $fell(clr_r), $past(clr_idx_r == CLR_LAST), "clear sweep ended early")

endmodule

// ===== verif/trie_shortest_unique_prefix_top_tb.sv =====
// testbench for trie_shortest_unique_prefix_top: queue-fed letter driver, result monitor
// and a behavioral trie predictor; depends on tsup_pkg and the top level only
`timescale 1ns / 1ps

module trie_shortest_unique_prefix_top_tb;
  import tsup_pkg::*;

  localparam int NODES     = DEF_POOL_NODES;
  localparam int ALPH      = DEF_ALPHABET;
  localparam int WORD_MAX  = DEF_MAX_WORD;
  localparam int WORD_CAP  = 80;
  localparam int HIST_CAP  = 200;
  localparam int RAND_ITEMS = 1000;
  // idle profile switches after this many accepted letters
  localparam int PHASE_A_END = 340;
  localparam int PHASE_B_END = 680;

  typedef struct packed {
    logic [WORD_CAP*LETTER_W-1:0] ltrs;
    int                           len;
  } word_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [LETTER_W-1:0] letter;
    logic                last;
    bit                  hold;
  } letter_item_t;

  typedef struct {
    status_t           status;
    logic [PLEN_W-1:0] plen;
  } word_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OPCODE_W-1:0] in_opcode = OP_INSERT;
  logic [LETTER_W-1:0] in_letter = '0;
  logic                in_last_of_word = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [PLEN_W-1:0]   out_prefix_length;

  trie_shortest_unique_prefix_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_letter         (in_letter),
    .in_last_of_word   (in_last_of_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_prefix_length (out_prefix_length)
  );

  always #4 clk = ~clk;

  letter_item_t letters_to_send[$];
  word_result_t prefix_results_due[$];
  word_t        inserted_words[$];
  int           letters_queued = 0;
  int           letters_taken = 0;
  int           mismatch_count = 0;
  bit           letter_taken = 1'b0;

  // trie shadow: child index per (node, symbol), 0 means no child
  int unsigned        child_of [NODES*ALPH];
  bit [COUNT_W-1:0]   node_pass [NODES];
  int unsigned        free_node = 1;
  int unsigned        walk_node = 0;
  int unsigned        walk_depth = 0;
  int unsigned        unique_len = 0;
  bit                 in_word = 1'b0;
  bit                 word_is_query = 1'b0;
  bit                 walk_stopped = 1'b0;
  bit                 unique_found = 1'b0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // advance the trie walk by one letter; a last letter yields the word's result
  function automatic void walk_letter(input logic [OPCODE_W-1:0] op,
                                      input logic [LETTER_W-1:0] letter, input logic last);
    int unsigned  sym;
    int unsigned  slot;
    int unsigned  child;
    bit           have;
    word_result_t res;
    if (!in_word) begin
      in_word = 1'b1;
      word_is_query = (op == OP_QUERY);
      walk_stopped = 1'b0;
      unique_found = 1'b0;
      walk_node = 0;
      walk_depth = 0;
      unique_len = 0;
    end
    if (!walk_stopped && walk_depth < WORD_MAX) begin
      sym = (letter >= ALPH) ? ALPH - 1 : letter;
      slot = walk_node * ALPH + sym;
      child = child_of[slot];
      have = (child != 0);
      if (!word_is_query) begin
        if (have) begin
          if (node_pass[child] != COUNT_MAX) node_pass[child]++;
        end else if (free_node < NODES) begin
          child = free_node;
          free_node++;
          node_pass[child] = 1;
          child_of[slot] = child;
          have = 1'b1;
        end
      end else if (have && !unique_found && node_pass[child] == 1) begin
        unique_len = walk_depth + 1;
        unique_found = 1'b1;
      end
      if (have) begin
        walk_node = child;
        walk_depth++;
      end else begin
        walk_stopped = 1'b1;
      end
    end
    if (last) begin
      res.plen = '0;
      if (!word_is_query) begin
        if (walk_stopped) res.status = ST_POOL_FULL;
        else res.status = ST_OK;
      end else if (walk_stopped) begin
        res.status = ST_NOT_FOUND;
      end else begin
        res.status = ST_OK;
        res.plen = unique_found ? unique_len[PLEN_W-1:0] : walk_depth[PLEN_W-1:0];
      end
      prefix_results_due.push_back(res);
      in_word = 1'b0;
    end
  endfunction

  function automatic int sender_idle_pct();
    if (letters_taken < PHASE_A_END) return 9;
    if (letters_taken < PHASE_B_END) return 67;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (letters_taken < PHASE_A_END) return 67;
    if (letters_taken < PHASE_B_END) return 9;
    return 0;
  endfunction

  // input acceptance sampled at the rising edge
  always @(posedge clk) begin
    letter_taken = rst_n && in_valid && !in_stall;
  end

  // letter driver: book the accepted transaction, then offer the next one
  always @(negedge clk) begin
    if (letter_taken) begin
      walk_letter(in_opcode, in_letter, in_last_of_word);
      void'(letters_to_send.pop_front());
      letters_taken++;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !letter_taken) begin
      // offered transaction still waiting, keep it steady
    end else if (letters_to_send.size() == 0 ||
                 (letters_to_send[0].hold && prefix_results_due.size() != 0) ||
                 $urandom_range(0, 99) < sender_idle_pct()) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= 1'b1;
      in_opcode <= letters_to_send[0].op;
      in_letter <= letters_to_send[0].letter;
      in_last_of_word <= letters_to_send[0].last;
    end
  end

  // result monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    word_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (prefix_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d len=%0d",
                                  out_status, out_prefix_length));
      end else begin
        want = prefix_results_due.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d", out_status, want.status));
        if (out_prefix_length !== want.plen)
          report_mismatch($sformatf("prefix_length %0d, predicted %0d",
                                    out_prefix_length, want.plen));
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < receiver_stall_pct());
  end

  function automatic word_t spell(input int n, input int a, input int b = 0,
                                  input int c = 0);
    word_t w;
    w = '0;
    w.len = n;
    w.ltrs[0 +: LETTER_W] = a[LETTER_W-1:0];
    w.ltrs[LETTER_W +: LETTER_W] = b[LETTER_W-1:0];
    w.ltrs[2*LETTER_W +: LETTER_W] = c[LETTER_W-1:0];
    return w;
  endfunction

  // narrow words share prefixes heavily, wide ones reach every letter code
  function automatic word_t rand_word(input int n, input bit wide);
    word_t w;
    w = '0;
    w.len = n;
    for (int i = 0; i < n; i++)
      w.ltrs[i*LETTER_W +: LETTER_W] = wide ? LETTER_W'($urandom_range(0, 31)) :
                                              LETTER_W'($urandom_range(0, 3));
    return w;
  endfunction

  // later letters carry random opcodes, only the first one governs the word
  task automatic queue_word(input logic [OPCODE_W-1:0] op, input word_t w, input bit hold);
    letter_item_t it;
    for (int i = 0; i < w.len; i++) begin
      it.op = (i == 0) ? op : OPCODE_W'($urandom_range(0, 1));
      it.letter = w.ltrs[i*LETTER_W +: LETTER_W];
      it.last = (i == w.len - 1);
      it.hold = hold && (i == 0);
      letters_to_send.push_back(it);
      letters_queued++;
    end
  endtask

  task automatic wait_drained();
    while (letters_to_send.size() != 0 || prefix_results_due.size() != 0) @(posedge clk);
  endtask

  // random word mix: inserts, replayed queries, prefixes, extensions and misses
  task automatic queue_random_word(input bit hold);
    word_t w;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      if ($urandom_range(0, 99) < 3) w = rand_word($urandom_range(60, 72), 1'b0);
      else w = rand_word($urandom_range(1, 6), $urandom_range(0, 9) == 0);
      queue_word(OP_INSERT, w, hold);
      inserted_words.push_back(w);
      if (inserted_words.size() > HIST_CAP) void'(inserted_words.pop_front());
    end else begin
      if (r < 85 && inserted_words.size() != 0) begin
        w = inserted_words[$urandom_range(0, inserted_words.size() - 1)];
        if ($urandom_range(0, 2) == 0) w.len = $urandom_range(1, w.len);
        if ($urandom_range(0, 9) == 0 && w.len < WORD_CAP) begin
          w.ltrs[w.len*LETTER_W +: LETTER_W] = LETTER_W'($urandom_range(0, 31));
          w.len++;
        end
      end else begin
        w = rand_word($urandom_range(1, 6), $urandom_range(0, 3) == 0);
      end
      queue_word(OP_QUERY, w, hold);
    end
  endtask

  initial begin : stimulus
    int n;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty trie, letter code extremes, shared and diverging paths
    queue_word(OP_QUERY,  spell(1, 0), 1'b1);
    queue_word(OP_INSERT, spell(1, 0), 1'b0);
    queue_word(OP_INSERT, spell(3, 31, 26, 25), 1'b0);
    queue_word(OP_INSERT, spell(2, 0, 1), 1'b0);
    // sender waits here until the earlier results are all back
    queue_word(OP_QUERY,  spell(2, 0, 1), 1'b1);
    queue_word(OP_QUERY,  spell(1, 0), 1'b0);
    queue_word(OP_QUERY,  spell(1, 26), 1'b0);
    queue_word(OP_QUERY,  spell(2, 0, 2), 1'b0);
    queue_word(OP_QUERY,  spell(3, 25, 31, 30), 1'b0);
    queue_word(OP_INSERT, spell(3, 16, 15, 8), 1'b0);
    queue_word(OP_QUERY,  spell(3, 16, 15, 8), 1'b0);
    queue_word(OP_INSERT, spell(2, 0, 1), 1'b0);
    queue_word(OP_QUERY,  spell(2, 0, 1), 1'b0);

    // random words with occasional pauses until the block drains
    n = letters_queued + RAND_ITEMS;
    while (letters_queued < n) queue_random_word($urandom_range(0, 49) == 0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (prefix_results_due.size() != 0) report_mismatch("predicted results never arrived");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit, several times the slowest expected run including the link sweep
  initial begin
    #9_600_000;
    $display("FAILURE");
    $finish;
  end

endmodule
